/* rtl/core/lcdw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdw_pkg
// Types and constants shared by the serial frame writer modules.
// ----------------------------------------------------------------------------
package lcdw_pkg;

	localparam int FRAME_W = 13;
	localparam int CNT_W   = 4;

	typedef enum logic [1:0] {
		REQ_COMMAND = 2'd0,
		REQ_NIBBLE  = 2'd1,
		REQ_OPEN    = 2'd2,
		REQ_BYTE    = 2'd3
	} req_t;

	// Frame prefixes: command is 1,0,0,0 and a write is 1,0,1.
	localparam logic [3:0] PREFIX_CMD = 4'b1000;
	localparam logic [2:0] PREFIX_WR  = 3'b101;

	localparam logic [CNT_W-1:0] LEN_CMD    = 4'd12;
	localparam logic [CNT_W-1:0] LEN_NIBBLE = 4'd13;
	localparam logic [CNT_W-1:0] LEN_OPEN   = 4'd9;
	localparam logic [CNT_W-1:0] LEN_BYTE   = 4'd8;
	localparam logic [CNT_W-1:0] LEN_REJECT = 4'd1;

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cmd_t;

	typedef struct packed {
		logic last_bit;
	} sts_t;

endpackage

/* rtl/core/lcdw_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdw_in_if / lcdw_out_if
// Valid/ready channels for write requests and serial bit words.
// ----------------------------------------------------------------------------
interface lcdw_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [5:0] address;
	logic [7:0] value;
	logic       close_burst;

	modport source (output valid, req_type, address, value, close_burst, input ready);
	modport sink (input valid, req_type, address, value, close_burst, output ready);
endinterface

interface lcdw_out_if;
	logic valid;
	logic ready;
	logic data_bit;
	logic last;
	logic frame_end;
	logic rejected;

	modport source (output valid, data_bit, last, frame_end, rejected, input ready);
	modport sink (input valid, data_bit, last, frame_end, rejected, output ready);
endinterface

/* rtl/core/lcdw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdw_ctrl
// Handshake controller: takes a request, then sends its bit words.
// ----------------------------------------------------------------------------
module lcdw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  lcdw_pkg::sts_t    sts,
	output lcdw_pkg::cmd_t    cmd
);

	lcdw_pkg::state_t state_q;
	lcdw_pkg::state_t state_d;
	logic             done;

	assign done = (state_q == lcdw_pkg::ST_SEND) && out_ready && sts.last_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcdw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lcdw_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = lcdw_pkg::ST_SEND;
				end
			end
			lcdw_pkg::ST_SEND: begin
				if (done && !in_valid) begin
					state_d = lcdw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lcdw_pkg::ST_IDLE;
			end
		endcase
	end

	// take the next request in the cycle the final word of this one leaves
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd.shift = 1'b0;
		case (state_q)
			lcdw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			lcdw_pkg::ST_SEND: begin
				in_ready  = done;
				out_valid = 1'b1;
				cmd.shift = out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.load = in_valid && in_ready;
	end

	a_no_shift_and_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcdw_pkg::ST_IDLE) |-> !cmd.shift)
		else $error("shift issued while idle");
	a_load_enters_send: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == lcdw_pkg::ST_SEND))
		else $error("load did not enter send");
	a_send_no_load_midframe: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && (state_q == lcdw_pkg::ST_SEND)) |-> (out_ready && sts.last_bit))
		else $error("request taken before frame finished");

endmodule

/* rtl/core/lcdw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdw_datapath
// Frame builder, shift register, bit counter and burst state.
// ----------------------------------------------------------------------------
module lcdw_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  lcdw_pkg::cmd_t cmd,
	output lcdw_pkg::sts_t sts,
	input  logic [1:0]     req_type,
	input  logic [5:0]     address,
	input  logic [7:0]     value,
	input  logic           close_burst,
	output logic           data_bit,
	output logic           last,
	output logic           frame_end,
	output logic           rejected
);

	logic [lcdw_pkg::FRAME_W-1:0] sh_q;
	logic [lcdw_pkg::CNT_W-1:0]   cnt_q;
	logic                         end_q;
	logic                         rej_q;
	logic                         burst_q;

	logic [lcdw_pkg::FRAME_W-1:0] word_d;
	logic [lcdw_pkg::CNT_W-1:0]   len_d;
	logic                         end_d;
	logic                         burst_d;
	logic                         reject;

	assign reject = (req_type == lcdw_pkg::REQ_BYTE) ? !burst_q : burst_q;

	// left-align each frame so the first bit sits at the top
	always_comb begin
		word_d  = '0;
		len_d   = lcdw_pkg::LEN_REJECT;
		end_d   = 1'b0;
		burst_d = burst_q;
		if (!reject) begin
			case (req_type)
				lcdw_pkg::REQ_COMMAND: begin
					word_d = {lcdw_pkg::PREFIX_CMD, value, 1'b0};
					len_d  = lcdw_pkg::LEN_CMD;
					end_d  = 1'b1;
				end
				lcdw_pkg::REQ_NIBBLE: begin
					word_d = {lcdw_pkg::PREFIX_WR, address, value[3:0]};
					len_d  = lcdw_pkg::LEN_NIBBLE;
					end_d  = 1'b1;
				end
				lcdw_pkg::REQ_OPEN: begin
					word_d  = {lcdw_pkg::PREFIX_WR, address, 4'b0000};
					len_d   = lcdw_pkg::LEN_OPEN;
					burst_d = 1'b1;
				end
				lcdw_pkg::REQ_BYTE: begin
					word_d = {value, 5'b00000};
					len_d  = lcdw_pkg::LEN_BYTE;
					end_d  = close_burst;
					if (close_burst) begin
						burst_d = 1'b0;
					end
				end
				default: begin
					word_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			burst_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q   <= len_d;
			burst_q <= burst_d;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh_q  <= word_d;
			end_q <= end_d;
			rej_q <= reject;
		end else if (cmd.shift) begin
			sh_q <= {sh_q[lcdw_pkg::FRAME_W-2:0], 1'b0};
		end
	end

	assign sts.last_bit = (cnt_q == lcdw_pkg::CNT_W'(1));
	assign data_bit     = sh_q[lcdw_pkg::FRAME_W-1];
	assign last         = sts.last_bit;
	assign frame_end    = sts.last_bit && end_q;
	assign rejected     = rej_q;

	a_shift_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> (cnt_q != '0))
		else $error("shift with empty counter");
	a_load_sets_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (cnt_q != '0))
		else $error("frame loaded with no bits");
	a_open_sets_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && (req_type == lcdw_pkg::REQ_OPEN) && !burst_q) |=> burst_q)
		else $error("burst open did not set burst state");
	a_reject_keeps_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && reject) |=> ($stable(burst_q) && rej_q && last))
		else $error("rejected request changed state");

endmodule

/* rtl/core/lcd_controller_serial_frame_writer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_controller_serial_frame_writer_top
// Serial frame writer for a three-wire segment LCD controller.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per word (command, nibble write, burst open,
//   burst byte). out_ch carries one serial bit per word, most significant
//   bit first, with last on the request's final word and frame_end on the
//   word after which chip select is released.
//   A request that does not fit the burst state gives one word with
//   rejected set and no bit sent; the burst state is left as it was.
//   The first bit appears in the cycle after the request is taken.
//   A request gives one output word per frame bit (12 for a
//   command, 13 for a nibble write, 9 for a burst open, 8 for a burst byte,
//   1 for a rejection), set by the single shift register that sends one bit
//   per word; the next request is taken in the cycle its final word leaves.
//   When out_ch stalls, the current bit holds and no new request is taken.
//   Reset clears the controller to idle and closes any open burst.
// ----------------------------------------------------------------------------
module lcd_controller_serial_frame_writer_top (
	input  logic             clk,
	input  logic             arst_n,
	lcdw_in_if.sink          in_ch,
	lcdw_out_if.source       out_ch
);

	lcdw_pkg::cmd_t cmd;
	lcdw_pkg::sts_t sts;

	lcdw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lcdw_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (in_ch.req_type),
		.address     (in_ch.address),
		.value       (in_ch.value),
		.close_burst (in_ch.close_burst),
		.data_bit    (out_ch.data_bit),
		.last        (out_ch.last),
		.frame_end   (out_ch.frame_end),
		.rejected    (out_ch.rejected)
	);

endmodule

/* bench/tb_lcd_controller_serial_frame_writer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcd_controller_serial_frame_writer_top
// Self-checking bench for the three-wire LCD serial frame writer.
// Sends command, nibble write and burst requests through the request channel.
// A local model predicts every serial bit word, including refusals that do
// not fit the burst state. Each word leaving the block is checked against
// the oldest prediction. Both channels idle at random, and one phase holds
// the output off for a long stretch.
// ----------------------------------------------------------------------------
module tb_lcd_controller_serial_frame_writer_top;

	localparam int          CYCLE_LIMIT = 200000;
	localparam int          TAIL_CYCLES = 20;
	localparam logic [3:0]  CMD_HEAD    = 4'b1000;
	localparam logic [2:0]  WRITE_HEAD  = 3'b101;

	typedef struct packed {
		logic data_bit;
		logic last;
		logic frame_end;
		logic rejected;
	} serial_word_t;

	logic clk;
	logic arst_n;

	lcdw_in_if  in_ch ();
	lcdw_out_if out_ch ();

	lcd_controller_serial_frame_writer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	serial_word_t expected_bits[$];
	logic         lcd_burst_open;
	bit           no_idle;
	int           hold_off_cycles;
	int           mismatch_count;
	int           requests_sent;
	int           refusals_sent;
	int           words_checked;
	int           cycle_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				expected_bits.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Work out the serial words one accepted request produces.
	function automatic void predict_frame_bits(lcdw_pkg::req_t kind, logic [5:0] addr,
			logic [7:0] val, logic close);
		logic [12:0]  bits;
		int           count;
		logic         ends;
		logic         refuse;
		serial_word_t w;
		bits   = '0;
		count  = 0;
		ends   = 1'b0;
		refuse = (kind == lcdw_pkg::REQ_BYTE) ? !lcd_burst_open : lcd_burst_open;
		requests_sent++;
		if (refuse) begin
			refusals_sent++;
			w = '{data_bit: 1'b0, last: 1'b1, frame_end: 1'b0, rejected: 1'b1};
			expected_bits.push_back(w);
			return;
		end
		case (kind)
			lcdw_pkg::REQ_COMMAND: begin
				bits  = {1'b0, CMD_HEAD, val};
				count = 12;
				ends  = 1'b1;
			end
			lcdw_pkg::REQ_NIBBLE: begin
				bits  = {WRITE_HEAD, addr, val[3:0]};
				count = 13;
				ends  = 1'b1;
			end
			lcdw_pkg::REQ_OPEN: begin
				bits           = {4'b0, WRITE_HEAD, addr};
				count          = 9;
				lcd_burst_open = 1'b1;
			end
			default: begin
				bits  = {5'b0, val};
				count = 8;
				ends  = close;
				if (close)
					lcd_burst_open = 1'b0;
			end
		endcase
		for (int i = count - 1; i >= 0; i--) begin
			w.data_bit  = bits[i];
			w.last      = (i == 0);
			w.frame_end = (i == 0) && ends;
			w.rejected  = 1'b0;
			expected_bits.push_back(w);
		end
	endfunction

	// Offer one request after a random gap; return at the edge that takes it.
	task automatic send_request(lcdw_pkg::req_t kind, logic [5:0] addr, logic [7:0] val,
			logic close);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.req_type    <= kind;
		in_ch.address     <= addr;
		in_ch.value       <= val;
		in_ch.close_burst <= close;
		do @(negedge clk); while (!in_ch.ready);
		predict_frame_bits(kind, addr, val, close);
		@(posedge clk);
	endtask

	task automatic send_random(bit well_formed);
		lcdw_pkg::req_t kind;
		if (!well_formed)
			kind = lcdw_pkg::req_t'($urandom_range(0, 3));
		else if (lcd_burst_open)
			kind = lcdw_pkg::REQ_BYTE;
		else
			kind = lcdw_pkg::req_t'($urandom_range(0, 2));
		send_request(kind, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
			(kind == lcdw_pkg::REQ_BYTE && well_formed) ? ($urandom_range(0, 3) == 0)
			: 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_bits.size() != 0)
			@(posedge clk);
	endtask

	// Output side: after any requested hold-off, stall for a random gap before each word unless no_idle is set.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(negedge clk);
			while (!(out_ch.valid && out_ch.ready) && hold_off_cycles == 0);
			@(posedge clk);
		end
	end

	// Check each word at the falling edge before the edge that takes it.
	always @(negedge clk) begin
		serial_word_t got;
		serial_word_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{data_bit: out_ch.data_bit, last: out_ch.last,
				frame_end: out_ch.frame_end, rejected: out_ch.rejected};
			if (expected_bits.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected word data_bit=%b last=%b frame_end=%b rejected=%b",
					$time, got.data_bit, got.last, got.frame_end, got.rejected);
			end else begin
				want = expected_bits.pop_front();
				words_checked++;
				if (got !== want) begin
					mismatch_count++;
					$display("%0t: word %0d expected data_bit=%b last=%b frame_end=%b rejected=%b",
						$time, words_checked, want.data_bit, want.last, want.frame_end,
						want.rejected);
					$display("%0t: word %0d actual   data_bit=%b last=%b frame_end=%b rejected=%b",
						$time, words_checked, got.data_bit, got.last, got.frame_end,
						got.rejected);
				end
			end
		end
	end

	// Field extremes, every request type and every refusal case.
	task automatic test_directed();
		no_idle = 1'b0;
		send_request(lcdw_pkg::REQ_COMMAND, 6'd0,  8'h00, 1'b0);
		send_request(lcdw_pkg::REQ_COMMAND, 6'd63, 8'hFF, 1'b1);
		send_request(lcdw_pkg::REQ_COMMAND, 6'd21, 8'hA5, 1'b0);
		send_request(lcdw_pkg::REQ_NIBBLE,  6'd0,  8'h00, 1'b0);
		send_request(lcdw_pkg::REQ_NIBBLE,  6'd63, 8'hFF, 1'b1);
		send_request(lcdw_pkg::REQ_NIBBLE,  6'd42, 8'hF5, 1'b0);
		send_request(lcdw_pkg::REQ_BYTE,    6'd5,  8'hC3, 1'b1);
		send_request(lcdw_pkg::REQ_OPEN,    6'd63, 8'h00, 1'b0);
		send_request(lcdw_pkg::REQ_OPEN,    6'd10, 8'h33, 1'b0);
		send_request(lcdw_pkg::REQ_COMMAND, 6'd0,  8'h81, 1'b0);
		send_request(lcdw_pkg::REQ_NIBBLE,  6'd7,  8'h0C, 1'b1);
		send_request(lcdw_pkg::REQ_BYTE,    6'd63, 8'hFF, 1'b0);
		send_request(lcdw_pkg::REQ_BYTE,    6'd0,  8'h00, 1'b0);
		send_request(lcdw_pkg::REQ_BYTE,    6'd33, 8'h5A, 1'b1);
		send_request(lcdw_pkg::REQ_BYTE,    6'd0,  8'h96, 1'b0);
		send_request(lcdw_pkg::REQ_OPEN,    6'd0,  8'hFF, 1'b1);
		send_request(lcdw_pkg::REQ_BYTE,    6'd12, 8'hA5, 1'b1);
		send_request(lcdw_pkg::REQ_COMMAND, 6'd63, 8'h3C, 1'b1);
		wait_drained();
	endtask

	// Hold the output off while requests keep coming, so the input stalls.
	task automatic test_output_hold_off();
		no_idle         = 1'b1;
		hold_off_cycles = 300;
		send_request(lcdw_pkg::REQ_OPEN, 6'd17, 8'h00, 1'b0);
		repeat (6) send_random(1'b1);
		send_request(lcdw_pkg::REQ_BYTE, 6'd0, 8'h69, 1'b1);
		repeat (4) send_random(1'b1);
		no_idle = 1'b0;
		wait_drained();
	endtask

	// Let every outstanding word drain between short groups of requests.
	task automatic test_drain_between_groups();
		for (int g = 0; g < 4; g++) begin
			repeat (3) send_random(1'b1);
			wait_drained();
		end
	endtask

	// Mostly well-formed frames with random content, some noise mixed in.
	task automatic test_random_frames();
		for (int n = 0; n < 190; n++) begin
			no_idle = ((n % 40) >= 28);
			send_random($urandom_range(0, 4) != 0);
		end
		no_idle = 1'b0;
		wait_drained();
	endtask

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.req_type    = lcdw_pkg::REQ_COMMAND;
		in_ch.address     = '0;
		in_ch.value       = '0;
		in_ch.close_burst = 1'b0;
		lcd_burst_open    = 1'b0;
		no_idle           = 1'b0;
		hold_off_cycles   = 0;
		mismatch_count    = 0;
		requests_sent     = 0;
		refusals_sent     = 0;
		words_checked     = 0;
		cycle_count       = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_output_hold_off();
		test_drain_between_groups();
		test_random_frames();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d requests sent, %0d of them refused by burst state",
			requests_sent, refusals_sent);
		$display("%0d serial words checked over %0d cycles, with long output hold-off",
			words_checked, cycle_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
